### src/rvt_pkg.sv
// Package: shared types and constants of the voxel traversal block.
`timescale 1ns / 1ps
package rvt_pkg;

	localparam int COORD_W     = 20;
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int IDX_W       = 12;
	localparam int LEN_W       = 21;
	localparam int PQ_W        = 21;
	localparam int SQ_W        = 42;
	localparam int MAX_RESULTS = 48;
	localparam int ITER_CAP    = 4 * MAX_RESULTS;
	localparam int CNT_W       = 6;
	localparam int ITER_W      = 8;
	localparam int AXIS_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] start_z;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COORD_W-1:0] end_z;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] voxel_index;
		logic [LEN_W-1:0] segment_length;
		logic             is_last;
	} out_item_t;

	typedef struct packed {
		logic              load;
		logic              sq_en;
		logic [AXIS_W-1:0] axis;
		logic              root_start;
		logic              root_store;
		logic              mul_en;
		logic              div_start;
		logic              div_step;
		logic              div_store;
		logic              walk_en;
	} cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
		logic walk_done;
	} sts_t;

endpackage

### src/rvt_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module rvt_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rvt_pkg::SQ_W-1:0]   value,
	output logic [rvt_pkg::PQ_W-1:0]   root,
	output logic                       done
);
	import rvt_pkg::*;

	localparam int CW = $clog2(PQ_W + 1);

	logic [SQ_W-1:0] v_q, res_q, bit_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q, done_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(PQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[PQ_W-1:0];
	assign done = done_q;
endmodule

### src/rvt_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rvt_div #(
	parameter int DW = 38
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DW-1:0]                 dividend,
	input  logic [rvt_pkg::COORD_W-1:0]   divisor,
	output logic [DW-1:0]                 quotient,
	output logic                          done
);
	import rvt_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]      q_q;
	logic [COORD_W:0]   rem_q, rem_sh;
	logic [COORD_W-1:0] dvs_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q, done_q;

	assign rem_sh = {rem_q[COORD_W-1:0], q_q[DW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sh - {1'b0, dvs_q};
				q_q   <= {q_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;
	assign done     = done_q;
endmodule

### src/rvt_ctrl.sv
// Controller: sequences setup arithmetic and the grid walk of one segment.
`timescale 1ns / 1ps
module rvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output rvt_pkg::cmd_t cmd,
	input  rvt_pkg::sts_t sts
);
	import rvt_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SQ    = 4'd1;
	localparam logic [3:0] S_ROOT  = 4'd2;
	localparam logic [3:0] S_RWAIT = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_DRUN  = 4'd5;
	localparam logic [3:0] S_WRUN  = 4'd6;
	localparam logic [3:0] S_DSTEP = 4'd7;
	localparam logic [3:0] S_WSTEP = 4'd8;
	localparam logic [3:0] S_WALK  = 4'd9;

	logic [3:0]        state_q, state_d;
	logic [AXIS_W-1:0] axis_q, axis_d;

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd      = '0;
		cmd.axis = axis_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					axis_d   = AXIS_X;
					state_d  = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq_en = 1'b1;
				if (axis_q == AXIS_Z) begin
					axis_d  = AXIS_X;
					state_d = S_ROOT;
				end else begin
					axis_d = axis_q + 1'b1;
				end
			end
			S_ROOT: begin
				cmd.root_start = 1'b1;
				state_d        = S_RWAIT;
			end
			S_RWAIT: begin
				if (sts.root_done) begin
					cmd.root_store = 1'b1;
					state_d        = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_DRUN;
			end
			S_DRUN: begin
				cmd.div_start = 1'b1;
				state_d       = S_WRUN;
			end
			S_WRUN: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = S_DSTEP;
				end
			end
			S_DSTEP: begin
				cmd.div_start = 1'b1;
				cmd.div_step  = 1'b1;
				state_d       = S_WSTEP;
			end
			S_WSTEP: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (axis_q == AXIS_Z) begin
						state_d = S_WALK;
					end else begin
						axis_d  = axis_q + 1'b1;
						state_d = S_MUL;
					end
				end
			end
			S_WALK: begin
				cmd.walk_en = 1'b1;
				if (sts.walk_done)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= AXIS_X;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end
endmodule

### src/rvt_datapath.sv
// Datapath: segment length, per-axis boundary setup, grid walk and result register.
`timescale 1ns / 1ps
module rvt_datapath #(
	parameter int MAX_GRID  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rvt_pkg::cmd_t                cmd,
	output rvt_pkg::sts_t                sts,
	input  rvt_pkg::in_item_t            in_item,
	input  logic [rvt_pkg::CFG_W-1:0]    grid_x,
	input  logic [rvt_pkg::CFG_W-1:0]    grid_y,
	input  logic [rvt_pkg::CFG_W-1:0]    grid_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rvt_pkg::out_item_t           out_item
);
	import rvt_pkg::*;

	localparam int GW     = $clog2(MAX_GRID + 1);
	localparam int INT_W  = COORD_W - FRAC_BITS;
	localparam int IW     = INT_W + 10;
	localparam int DIST_W = FRAC_BITS + 1;
	localparam int DW     = PQ_W + DIST_W;
	localparam int RW     = DW + 1;
	localparam int FW     = (3 * GW + 2 > IDX_W) ? 3 * GW + 2 : IDX_W;

	logic [COORD_W-1:0] a_in [3];
	logic [COORD_W-1:0] b_in [3];

	logic [COORD_W-1:0]   d_q    [3];
	logic                 up_q   [3];
	logic                 still_q[3];
	logic [DIST_W-1:0]    dist_q [3];
	logic signed [IW-1:0] pos_q  [3];
	logic [RW-1:0]        run_q  [3];
	logic [DW-1:0]        step_q [3];

	logic [SQ_W-1:0]   sq_acc_q;
	logic [PQ_W-1:0]   pq_q, root;
	logic [DW-1:0]     prod_q, div_in, quot;
	logic              root_done, div_done;
	logic [GW-1:0]     ex, ey, ez;
	logic [2*GW-1:0]   plane_q;
	logic [PQ_W-1:0]   prev_q;
	logic [CNT_W-1:0]  n_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	out_item_t         out_q;

	assign a_in[0] = in_item.start_x;
	assign a_in[1] = in_item.start_y;
	assign a_in[2] = in_item.start_z;
	assign b_in[0] = in_item.end_x;
	assign b_in[1] = in_item.end_y;
	assign b_in[2] = in_item.end_z;

	function automatic logic [GW-1:0] eff_size(input logic [CFG_W-1:0] g);
		logic [GW-1:0] r;
		if (g == '0)
			r = GW'(1);
		else if (32'(g) > MAX_GRID)
			r = GW'(MAX_GRID);
		else
			r = GW'(g);
		return r;
	endfunction

	function automatic logic [GW-1:0] clamp(input logic signed [IW-1:0] c,
			input logic [GW-1:0] size);
		logic [GW-1:0] r;
		if (c < 0)
			r = '0;
		else if (c >= $signed({{(IW-GW){1'b0}}, size}))
			r = size - 1'b1;
		else
			r = c[GW-1:0];
		return r;
	endfunction

	assign ex = eff_size(grid_x);
	assign ey = eff_size(grid_y);
	assign ez = eff_size(grid_z);

	// per-axis setup captured with the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				up_q[i]    <= b_in[i] > a_in[i];
				still_q[i] <= b_in[i] == a_in[i];
				d_q[i]     <= (b_in[i] > a_in[i]) ? b_in[i] - a_in[i] : a_in[i] - b_in[i];
				dist_q[i]  <= (b_in[i] > a_in[i]) ?
					(DIST_W'(1) << FRAC_BITS) - {1'b0, a_in[i][FRAC_BITS-1:0]} :
					{1'b0, a_in[i][FRAC_BITS-1:0]};
			end
			plane_q  <= (2*GW)'(ex) * (2*GW)'(ey);
			sq_acc_q <= '0;
		end else if (cmd.sq_en) begin
			sq_acc_q <= sq_acc_q + SQ_W'(d_q[cmd.axis] * d_q[cmd.axis]);
		end
		if (cmd.root_store)
			pq_q <= root;
		if (cmd.mul_en)
			prod_q <= DW'(pq_q) * DW'(dist_q[cmd.axis]);
		if (cmd.div_store && cmd.div_step)
			step_q[cmd.axis] <= still_q[cmd.axis] ? '0 : quot;
	end

	rvt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.value  (sq_acc_q),
		.root   (root),
		.done   (root_done)
	);

	assign div_in = cmd.div_step ? {1'b0, pq_q, {FRAC_BITS{1'b0}}} : prod_q;

	rvt_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_in),
		.divisor  (d_q[cmd.axis]),
		.quotient (quot),
		.done     (div_done)
	);

	// grid walk, one step per cycle while the result slot is free
	logic [RW-1:0]    t;
	logic             slot_free, go, fin, emit, sel_x, sel_y;
	logic [GW-1:0]    cx, cy, cz;
	logic [FW-1:0]    flat;
	logic [PQ_W-1:0]  t_len;

	assign slot_free = !out_valid_q || out_ready;
	assign go        = cmd.walk_en && slot_free;

	always_comb begin
		t = run_q[0];
		if (run_q[1] < t) t = run_q[1];
		if (run_q[2] < t) t = run_q[2];
	end

	assign fin   = (t >= RW'(pq_q)) || (n_q == CNT_W'(MAX_RESULTS - 1))
	               || (iter_q >= ITER_W'(ITER_CAP));
	assign emit  = t > RW'(prev_q);
	assign t_len = t[PQ_W-1:0] - prev_q;
	assign sel_x = (run_q[0] < run_q[1]) && (run_q[0] < run_q[2]);
	assign sel_y = !(run_q[0] < run_q[1]) && (run_q[1] < run_q[2]);

	assign cx   = clamp(pos_q[0], ex);
	assign cy   = clamp(pos_q[1], ey);
	assign cz   = clamp(pos_q[2], ez);
	assign flat = FW'(cz) * FW'(plane_q) + FW'(cy) * FW'(ex) + FW'(cx);

	always_ff @(posedge clk) begin
		// first boundary distance of an axis, loaded during setup
		if (cmd.div_store && !cmd.div_step)
			run_q[cmd.axis] <= still_q[cmd.axis] ? '1 : {1'b0, quot};
		if (cmd.load) begin
			for (int i = 0; i < 3; i++)
				pos_q[i] <= $signed({{(IW-INT_W){1'b0}}, a_in[i][COORD_W-1:FRAC_BITS]});
			prev_q <= '0;
			n_q    <= '0;
			iter_q <= '0;
		end else if (go && !fin) begin
			if (emit) begin
				n_q    <= n_q + 1'b1;
				prev_q <= t[PQ_W-1:0];
			end
			iter_q <= iter_q + 1'b1;
			for (int i = 0; i < 3; i++) begin
				if ((i == 0 && sel_x) || (i == 1 && sel_y) || (i == 2 && !sel_x && !sel_y)) begin
					if (!still_q[i]) begin
						pos_q[i] <= up_q[i] ? pos_q[i] + 1'b1 : pos_q[i] - 1'b1;
						run_q[i] <= run_q[i] + RW'(step_q[i]);
					end
				end
			end
		end
		if (go && (fin || emit)) begin
			out_q.voxel_index    <= flat[IDX_W-1:0];
			out_q.segment_length <= fin ? pq_q - prev_q : t_len;
			out_q.is_last        <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (go && (fin || emit))
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign sts.root_done = root_done;
	assign sts.div_done  = div_done;
	assign sts.walk_done = go && fin;
	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
endmodule

### src/ray_voxel_traversal_lengths.sv
// Top level: voxel path lengths of a 3D segment, grid size registers and glue.
//
// Usage: one segment per transaction on the input channel (in_valid/in_ready,
// in_item holds both endpoints in unsigned Q4.16). For every voxel crossed
// with a nonzero length a result transaction leaves on out_valid/out_ready:
// flat voxel index, Q5.16 length and is_last on the final voxel.
// Grid sizes are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, the block itself does not enforce this.
// Setup per segment: squares of three axes, the bit-serial root, then per
// axis one multiply and two divisions (DW = 22 + FRAC_BITS), most of it on
// the shared divider; then the walk makes one grid step per cycle while the
// output register is free, at most 192 steps and 48 results.
// One segment is in flight at a time; in_ready rises once the last result
// has been placed in the output register, so the next setup overlaps it.
// Output stalls hold the walk; the output register keeps its transaction.
// Reset clears control state and sets all grid sizes to 16.
`timescale 1ns / 1ps
module ray_voxel_traversal_lengths #(
	parameter int MAX_GRID  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rvt_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rvt_pkg::out_item_t               out_item,
	input  logic                             cfg_we,
	input  logic [rvt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rvt_pkg::CFG_W-1:0]        cfg_data
);
	import rvt_pkg::*;

	logic [CFG_W-1:0] grid_x_q, grid_y_q, grid_z_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= CFG_W'(16);
			grid_y_q <= CFG_W'(16);
			grid_z_q <= CFG_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_X: grid_x_q <= cfg_data;
				REG_GRID_Y: grid_y_q <= cfg_data;
				REG_GRID_Z: grid_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rvt_datapath #(.MAX_GRID(MAX_GRID), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.grid_x    (grid_x_q),
		.grid_y    (grid_y_q),
		.grid_z    (grid_z_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.is_last || out_item.segment_length != '0)
		else $error("zero-length result that is not the last");

	a_walk_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_en |-> !in_ready)
		else $error("walk running while input is open");
endmodule
